// ----- hw/rtl/windowed_cross_interval_engine_unit_defines.svh -----
// assertion macros shared by the checking code of the interval engine
`ifndef WINDOWED_CROSS_INTERVAL_ENGINE_UNIT_DEFINES_SVH
`define WINDOWED_CROSS_INTERVAL_ENGINE_UNIT_DEFINES_SVH

// same-cycle implication, quiet during reset
`define WCIE_ASSERT_NOW(label, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error(msg);

// next-cycle implication, quiet during reset
`define WCIE_ASSERT_NEXT(label, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`endif

// ----- hw/rtl/wcie_pkg.sv -----
`timescale 1ns / 1ps

package wcie_pkg;

    localparam int STAMP_W  = 32;
    localparam int CLASS_W  = 8;
    localparam int IVAL_W   = STAMP_W + 1;
    localparam int COUNT_W  = 32;
    localparam int DEPTH    = 32;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int FILL_W   = $clog2(DEPTH + 1);
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = CLASS_W;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_REF_CLASS    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_CLASS = 1'd1;

    // item operations
    localparam logic OP_EVENT  = 1'b0;
    localparam logic OP_WINDOW = 1'b1;

    // role bits of a buffered entry
    localparam int ROLE_REF_BIT = 0;
    localparam int ROLE_TGT_BIT = 1;

    typedef struct packed {
        logic accept;
        logic rd;
        logic gen_a;
        logic gen_b;
        logic flush;
    } wcie_cmd_t;

    typedef struct packed {
        logic evt_hit;
        logic more;
        logic need_a;
        logic need_b;
        logic can_gen;
        logic hold_valid;
    } wcie_sts_t;

endpackage

// ----- hw/rtl/wcie_ctrl.sv -----
`timescale 1ns / 1ps

module wcie_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  wcie_pkg::wcie_sts_t sts,
    output wcie_pkg::wcie_cmd_t cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_WALK   = 3'd1;
    localparam logic [2:0] S_EVAL_A = 3'd2;
    localparam logic [2:0] S_EVAL_B = 3'd3;
    localparam logic [2:0] S_FLUSH  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (sts.evt_hit)
                    begin
                        state_next = S_WALK;
                    end
                end
            end
            S_WALK:
            begin
                if (sts.more)
                begin
                    cmd.rd     = 1'b1;
                    state_next = S_EVAL_A;
                end
                else
                begin
                    state_next = S_FLUSH;
                end
            end
            S_EVAL_A:
            begin
                // new event as reference first
                if (!sts.need_a || sts.can_gen)
                begin
                    cmd.gen_a = sts.need_a;
                    if (sts.need_b)
                    begin
                        state_next = S_EVAL_B;
                    end
                    else if (sts.more)
                    begin
                        cmd.rd = 1'b1;
                    end
                    else
                    begin
                        state_next = S_FLUSH;
                    end
                end
            end
            S_EVAL_B:
            begin
                if (sts.can_gen)
                begin
                    cmd.gen_b = 1'b1;
                    if (sts.more)
                    begin
                        cmd.rd     = 1'b1;
                        state_next = S_EVAL_A;
                    end
                    else
                    begin
                        state_next = S_FLUSH;
                    end
                end
            end
            S_FLUSH:
            begin
                // held result goes out marked last
                if (!sts.hold_valid)
                begin
                    state_next = S_IDLE;
                end
                else if (sts.can_gen)
                begin
                    cmd.flush  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- hw/rtl/wcie_dp.sv -----
`timescale 1ns / 1ps

module wcie_dp
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_en,
    input  logic [wcie_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [wcie_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 operation,
    input  logic [wcie_pkg::STAMP_W-1:0]         stamp,
    input  logic [wcie_pkg::STAMP_W-1:0]         window_end,
    input  logic [wcie_pkg::CLASS_W-1:0]         event_class,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [wcie_pkg::IVAL_W-1:0]   interval,
    output logic                                 last,
    output logic                                 buffer_full,
    output logic [wcie_pkg::COUNT_W-1:0]         total_count,
    input  wcie_pkg::wcie_cmd_t                  cmd,
    output wcie_pkg::wcie_sts_t                  sts
);

    logic [wcie_pkg::CLASS_W-1:0]  ref_class_reg;
    logic [wcie_pkg::CLASS_W-1:0]  target_class_reg;
    logic [wcie_pkg::STAMP_W-1:0]  win_start_reg;
    logic [wcie_pkg::STAMP_W-1:0]  win_end_reg;
    logic                          win_open_reg;
    logic [wcie_pkg::FILL_W-1:0]   fill_reg;
    logic [wcie_pkg::FILL_W-1:0]   limit_reg;
    logic [wcie_pkg::FILL_W-1:0]   idx_reg;
    logic [wcie_pkg::STAMP_W-1:0]  evt_time_reg;
    logic [1:0]                    evt_role_reg;
    logic                          evt_full_reg;

    logic [wcie_pkg::STAMP_W-1:0]  mem_time [wcie_pkg::DEPTH];
    logic [1:0]                    mem_role [wcie_pkg::DEPTH];
    logic [wcie_pkg::STAMP_W-1:0]  rd_time_reg;
    logic [1:0]                    rd_role_reg;

    logic                          hold_valid_reg;
    logic [wcie_pkg::IVAL_W-1:0]   hold_ival_reg;
    logic                          hold_full_reg;
    logic [wcie_pkg::COUNT_W-1:0]  hold_count_reg;
    logic [wcie_pkg::COUNT_W-1:0]  total_reg;
    logic [wcie_pkg::COUNT_W-1:0]  total_next;

    logic                          out_valid_reg;
    logic [wcie_pkg::IVAL_W-1:0]   out_ival_reg;
    logic                          out_last_reg;
    logic                          out_full_reg;
    logic [wcie_pkg::COUNT_W-1:0]  out_count_reg;

    logic [1:0]                    role;
    logic                          in_window;
    logic                          is_full;
    logic                          store;
    logic                          gen;
    logic                          out_free;
    logic [wcie_pkg::IVAL_W-1:0]   new_ival;

    // role and window check of the incoming request
    always_comb
    begin
        role = 2'b00;
        role[wcie_pkg::ROLE_REF_BIT] = (event_class == ref_class_reg);
        role[wcie_pkg::ROLE_TGT_BIT] = (event_class == target_class_reg);
    end

    assign in_window = win_open_reg && (stamp >= win_start_reg) && (stamp < win_end_reg);
    assign is_full   = (fill_reg >= wcie_pkg::FILL_W'(wcie_pkg::DEPTH));
    assign store     = cmd.accept && sts.evt_hit && !is_full;
    assign gen       = cmd.gen_a || cmd.gen_b;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        sts            = '0;
        sts.evt_hit    = (operation == wcie_pkg::OP_EVENT) && in_window && (role != 2'b00);
        sts.more       = (idx_reg < limit_reg);
        sts.need_a     = evt_role_reg[wcie_pkg::ROLE_REF_BIT]
                         && rd_role_reg[wcie_pkg::ROLE_TGT_BIT];
        sts.need_b     = evt_role_reg[wcie_pkg::ROLE_TGT_BIT]
                         && rd_role_reg[wcie_pkg::ROLE_REF_BIT];
        sts.can_gen    = !hold_valid_reg || out_free;
        sts.hold_valid = hold_valid_reg;
    end

    // target minus reference, wrapped to the interval width
    always_comb
    begin
        if (cmd.gen_a)
        begin
            new_ival = {1'b0, rd_time_reg} - {1'b0, evt_time_reg};
        end
        else
        begin
            new_ival = {1'b0, evt_time_reg} - {1'b0, rd_time_reg};
        end
    end

    assign total_next = (total_reg == '1) ? total_reg : total_reg + 1'b1;

    // configuration, window, fill level, walk index, running count and hold/output valid state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_class_reg    <= wcie_pkg::CLASS_W'(1);
            target_class_reg <= wcie_pkg::CLASS_W'(2);
            win_start_reg    <= '0;
            win_end_reg      <= '0;
            win_open_reg     <= 1'b0;
            fill_reg         <= '0;
            limit_reg        <= '0;
            idx_reg          <= '0;
            total_reg        <= '0;
            hold_valid_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_en)
            begin
                unique case (cfg_index)
                    wcie_pkg::REG_REF_CLASS:    ref_class_reg    <= cfg_data;
                    wcie_pkg::REG_TARGET_CLASS: target_class_reg <= cfg_data;
                    default:                    ;
                endcase
            end
            if (cmd.accept && (operation == wcie_pkg::OP_WINDOW))
            begin
                win_start_reg <= stamp;
                win_end_reg   <= window_end;
                win_open_reg  <= 1'b1;
                fill_reg      <= '0;
            end
            if (cmd.accept && sts.evt_hit)
            begin
                // walk covers entries held before this event
                limit_reg <= fill_reg;
                idx_reg   <= '0;
            end
            else if (cmd.rd)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (store)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            if (gen)
            begin
                total_reg      <= total_next;
                hold_valid_reg <= 1'b1;
            end
            else if (cmd.flush)
            begin
                hold_valid_reg <= 1'b0;
            end
            if ((gen && hold_valid_reg) || cmd.flush)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // event buffer, registered read
    always_ff @(posedge clk)
    begin
        if (store)
        begin
            mem_time[fill_reg[wcie_pkg::ADDR_W-1:0]] <= stamp;
            mem_role[fill_reg[wcie_pkg::ADDR_W-1:0]] <= role;
        end
        if (cmd.rd)
        begin
            rd_time_reg <= mem_time[idx_reg[wcie_pkg::ADDR_W-1:0]];
            rd_role_reg <= mem_role[idx_reg[wcie_pkg::ADDR_W-1:0]];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept && sts.evt_hit)
        begin
            evt_time_reg <= stamp;
            evt_role_reg <= role;
            evt_full_reg <= is_full;
        end
        if (gen)
        begin
            hold_ival_reg  <= new_ival;
            hold_full_reg  <= evt_full_reg;
            hold_count_reg <= total_next;
        end
        if ((gen && hold_valid_reg) || cmd.flush)
        begin
            out_ival_reg  <= hold_ival_reg;
            out_last_reg  <= cmd.flush;
            out_full_reg  <= hold_full_reg;
            out_count_reg <= hold_count_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign interval    = out_ival_reg;
    assign last        = out_last_reg;
    assign buffer_full = out_full_reg;
    assign total_count = out_count_reg;

endmodule

// ----- hw/rtl/windowed_cross_interval_engine_unit.sv -----
`timescale 1ns / 1ps
// channel   | handshake           | payload
// ----------+---------------------+------------------------------------------
// input     | in_valid/in_ready   | operation, stamp, window_end, event_class
// output    | out_valid/out_ready | interval, last, buffer_full, total_count
// config    | cfg_en (no wait)    | cfg_index, cfg_data
//
// window requests and events that miss the window or both classes need no buffer walk
// a hitting event walks the entries buffered before it through the buffer read port, one entry at a time,
// with an extra step for each buffered reference met by a target; the walk covers at most 32 entries,
// and ends by handing the held final result, if one is held, to the output register
// reset clears window, fill level, running count and handshake state; buffer is not cleared
// a stalled output holds the walk; the next request is taken while a result still waits

module windowed_cross_interval_engine_unit
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_en,
    input  logic [wcie_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [wcie_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 operation,
    input  logic [wcie_pkg::STAMP_W-1:0]         stamp,
    input  logic [wcie_pkg::STAMP_W-1:0]         window_end,
    input  logic [wcie_pkg::CLASS_W-1:0]         event_class,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [wcie_pkg::IVAL_W-1:0]   interval,
    output logic                                 last,
    output logic                                 buffer_full,
    output logic [wcie_pkg::COUNT_W-1:0]         total_count
);

`include "windowed_cross_interval_engine_unit_defines.svh"

    // command and status between sequencer and datapath
    wcie_pkg::wcie_cmd_t cmd;
    wcie_pkg::wcie_sts_t sts;

    // sequencer: accepts requests, walks the buffer, flushes the last result
    wcie_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath: window registers, event buffer, hold stage and output register
    wcie_dp u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_en      (cfg_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .operation   (operation),
        .stamp       (stamp),
        .window_end  (window_end),
        .event_class (event_class),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .interval    (interval),
        .last        (last),
        .buffer_full (buffer_full),
        .total_count (total_count),
        .cmd         (cmd),
        .sts         (sts)
    );

    // nothing may be held back once a new request can be taken
    `WCIE_ASSERT_NOW(a_idle_hold_empty, in_ready, !sts.hold_valid, "result left in hold stage")

    // the walk must be finished when idle
    `WCIE_ASSERT_NOW(a_idle_walk_done, in_ready, !sts.more, "buffer walk still pending")

    // a result is only made when the hold stage can take it
    `WCIE_ASSERT_NOW(a_gen_room, cmd.gen_a || cmd.gen_b, sts.can_gen, "result made without room")

    // a flush lands in the output register as the last result
    `WCIE_ASSERT_NEXT(a_flush_last, cmd.flush, out_valid && last, "flushed result not marked last")

endmodule
